[src/stepper_position_step_generator_core_macros.svh]
// Assertion macros for the stepper step generator checker.
// Included by spg_checker; needs nothing else.
`ifndef STEPPER_POSITION_STEP_GENERATOR_CORE_MACROS_SVH
`define STEPPER_POSITION_STEP_GENERATOR_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SPG_ASSERT_HOLDS(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("spg assertion failed");

// Next-cycle implication, disabled during reset.
`define SPG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("spg assertion failed");

`endif

[src/spg_pkg.sv]
// Shared types, constants and microcode ROM of the stepper step generator.
// No dependencies; used by every module of the block.
`default_nettype none

package spg_pkg;

   localparam int TIME_W     = 32;
   localparam int RATE_W     = 24;
   localparam int ACC_W      = 40;
   localparam int PROD_W     = RATE_W + TIME_W;
   localparam int SUM_W      = PROD_W + 1;
   localparam int POS_PORT_W = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int UPC_W      = 4;
   localparam int MAX_RESULTS = 16;

   localparam int MAX_STEPS_DEFAULT     = 16;
   localparam int POSITION_BITS_DEFAULT = 32;

   // one step = 1e6 * 256 accumulator units
   localparam logic [ACC_W-1:0]  ONE_STEP_UNITS = 40'd256000000;
   localparam logic [ACC_W-1:0]  TWO_STEP_UNITS = 40'd512000000;
   localparam logic [RATE_W-1:0] DEFAULT_RATE   = 24'd256;

   typedef enum logic [1:0] {
      REQ_TICK = 2'd0,
      REQ_MOVE = 2'd1,
      REQ_SET  = 2'd2
   } req_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RISE_RATE    = 2'd0,
      CSR_FALL_RATE    = 2'd1,
      CSR_INVERT_DIR   = 2'd2,
      CSR_MOTOR_ENABLE = 2'd3
   } csr_idx_type;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_MOVE,
      OP_SETPOS,
      OP_SYNC,
      OP_MUL,
      OP_ACCUM,
      OP_STEP,
      OP_STATUS
   } uop_type;

   typedef enum logic [2:0] {
      COND_NONE,
      COND_ALWAYS,
      COND_IS_MOVE,
      COND_IS_SET,
      COND_NO_TICK,
      COND_AT_TARGET,
      COND_NO_STEP,
      COND_MORE
   } cond_type;

   typedef struct packed {
      uop_type           op;
      cond_type          cond;
      logic [UPC_W-1:0]  target;
      logic              done;
   } uword_type;

   // sequencer -> datapath
   typedef struct packed {
      logic    start;
      logic    exec;
      uop_type op;
   } dp_ctl_type;

   // datapath -> sequencer
   typedef struct packed {
      logic is_move;
      logic is_set;
      logic no_tick;
      logic at_target;
      logic no_step;
      logic more;
      logic slot_free;
   } dp_flags_type;

   localparam logic [UPC_W-1:0] L_SYNC   = 4'd8;
   localparam logic [UPC_W-1:0] L_MOVE   = 4'd9;
   localparam logic [UPC_W-1:0] L_SET    = 4'd10;
   localparam logic [UPC_W-1:0] L_STATUS = 4'd11;
   localparam logic [UPC_W-1:0] L_STEP   = 4'd7;

   function automatic uword_type spg_urom(input logic [UPC_W-1:0] addr);
      uword_type w;
      unique case (addr)
         4'd0:    w = '{op: OP_NOP,    cond: COND_IS_MOVE,   target: L_MOVE,   done: 1'b0};
         4'd1:    w = '{op: OP_NOP,    cond: COND_IS_SET,    target: L_SET,    done: 1'b0};
         4'd2:    w = '{op: OP_NOP,    cond: COND_NO_TICK,   target: L_STATUS, done: 1'b0};
         4'd3:    w = '{op: OP_NOP,    cond: COND_AT_TARGET, target: L_SYNC,   done: 1'b0};
         4'd4:    w = '{op: OP_MUL,    cond: COND_NONE,      target: L_STATUS, done: 1'b0};
         4'd5:    w = '{op: OP_ACCUM,  cond: COND_NONE,      target: L_STATUS, done: 1'b0};
         4'd6:    w = '{op: OP_NOP,    cond: COND_NO_STEP,   target: L_STATUS, done: 1'b0};
         4'd7:    w = '{op: OP_STEP,   cond: COND_MORE,      target: L_STEP,   done: 1'b1};
         4'd8:    w = '{op: OP_SYNC,   cond: COND_ALWAYS,    target: L_STATUS, done: 1'b0};
         4'd9:    w = '{op: OP_MOVE,   cond: COND_ALWAYS,    target: L_STATUS, done: 1'b0};
         4'd10:   w = '{op: OP_SETPOS, cond: COND_ALWAYS,    target: L_STATUS, done: 1'b0};
         default: w = '{op: OP_STATUS, cond: COND_NONE,      target: L_STATUS, done: 1'b1};
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

[src/spg_sequencer.sv]
// Microcode sequencer: step counter, ROM fetch and conditional jumps.
// Depends on spg_pkg.
`default_nettype none

module spg_sequencer (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire spg_pkg::dp_flags_type flags,
   output spg_pkg::dp_ctl_type        ctl
);
   import spg_pkg::*;

   logic             busy_ff, busy_in;
   logic [UPC_W-1:0] upc_ff, upc_in;
   uword_type        uw;
   logic             is_emit;
   logic             taken;
   logic             exec;

   assign uw      = spg_urom(upc_ff);
   assign is_emit = (uw.op == OP_STEP) || (uw.op == OP_STATUS);
   assign exec    = busy_ff && (!is_emit || flags.slot_free);

   always_comb begin
      unique case (uw.cond)
         COND_NONE:      taken = 1'b0;
         COND_ALWAYS:    taken = 1'b1;
         COND_IS_MOVE:   taken = flags.is_move;
         COND_IS_SET:    taken = flags.is_set;
         COND_NO_TICK:   taken = flags.no_tick;
         COND_AT_TARGET: taken = flags.at_target;
         COND_NO_STEP:   taken = flags.no_step;
         COND_MORE:      taken = flags.more;
         default:        taken = 1'b0;
      endcase
   end

   always_comb begin
      busy_in = busy_ff;
      upc_in  = upc_ff;
      if (!busy_ff) begin
         if (req_valid) begin
            busy_in = 1'b1;
            upc_in  = '0;
         end
      end else if (exec) begin
         if (taken) begin
            upc_in = uw.target;
         end else if (uw.done) begin
            busy_in = 1'b0;
         end else begin
            upc_in = upc_ff + UPC_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         upc_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         upc_ff  <= upc_in;
      end
   end

   assign req_stall = busy_ff;
   assign ctl.start = req_valid && !busy_ff;
   assign ctl.exec  = exec;
   assign ctl.op    = busy_ff ? uw.op : OP_NOP;

endmodule

`default_nettype wire

[src/spg_datapath.sv]
// Datapath: config registers, motion state, rate multiplier, saturating
// accumulator and the result register. Depends on spg_pkg.
`default_nettype none

module spg_datapath #(
   parameter int MAX_STEPS_PER_TICK = spg_pkg::MAX_STEPS_DEFAULT,
   parameter int POSITION_BITS      = spg_pkg::POSITION_BITS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_write_enable,
   input  wire logic [spg_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [spg_pkg::RATE_W-1:0]        csr_write_data,
   input  wire logic [1:0]                        req_type,
   input  wire logic [spg_pkg::TIME_W-1:0]        req_now_us,
   input  wire logic signed [spg_pkg::POS_PORT_W-1:0] req_position_value,
   input  wire spg_pkg::dp_ctl_type               ctl,
   output spg_pkg::dp_flags_type                  flags,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic                                   rsp_step_pulse,
   output logic                                   rsp_direction_level,
   output logic signed [spg_pkg::POS_PORT_W-1:0]  rsp_position_now,
   output logic                                   rsp_moving,
   output logic                                   rsp_last_of_run
);
   import spg_pkg::*;

   localparam int PB       = POSITION_BITS;
   localparam int STEP_CAP = (MAX_STEPS_PER_TICK < MAX_RESULTS) ? MAX_STEPS_PER_TICK
                                                                : MAX_RESULTS;
   localparam int CNT_W    = $clog2(STEP_CAP + 1);

   // config
   logic [RATE_W-1:0] rise_ff, rise_in, fall_ff, fall_in;
   logic              inv_ff, inv_in, en_ff, en_in;
   // held request
   logic [1:0]            type_ff, type_in;
   logic [TIME_W-1:0]     now_ff, now_in;
   logic signed [PB-1:0]  value_ff, value_in;
   // motion state
   logic signed [PB-1:0]  cur_ff, cur_in, tgt_ff, tgt_in;
   logic [RATE_W-1:0]     rate_ff, rate_in;
   logic [ACC_W-1:0]      acc_ff, acc_in;
   logic [TIME_W-1:0]     last_ff, last_in;
   logic                  fwd_ff, fwd_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   // result register
   logic                  vld_ff, vld_in;
   logic                  pulse_ff, pulse_in;
   logic                  dir_ff, dir_in;
   logic signed [POS_PORT_W-1:0] pos_ff, pos_in;
   logic                  mov_ff, mov_in;
   logic                  last_run_ff, last_run_in;

   logic                  step_up;
   logic signed [PB-1:0]  cur_step;
   logic [TIME_W-1:0]     dt;
   logic [SUM_W-1:0]      sum;
   logic                  more;
   logic [RATE_W-1:0]     rise_eff, fall_eff;

   assign step_up  = tgt_ff > cur_ff;
   assign cur_step = step_up ? cur_ff + PB'(1) : cur_ff - PB'(1);
   assign dt       = now_ff - last_ff;
   assign sum      = SUM_W'(acc_ff) + SUM_W'(prod_ff);
   assign rise_eff = (rise_ff == '0) ? DEFAULT_RATE : rise_ff;
   assign fall_eff = (fall_ff == '0) ? DEFAULT_RATE : fall_ff;
   // another step follows this one
   assign more     = (acc_ff >= TWO_STEP_UNITS) && (cur_step != tgt_ff) &&
                     (cnt_ff < CNT_W'(STEP_CAP - 1));

   assign flags.is_move   = (type_ff == REQ_MOVE);
   assign flags.is_set    = (type_ff == REQ_SET);
   assign flags.no_tick   = (type_ff != REQ_TICK) || !en_ff;
   assign flags.at_target = (cur_ff == tgt_ff);
   assign flags.no_step   = (acc_ff < ONE_STEP_UNITS);
   assign flags.more      = more;
   assign flags.slot_free = !vld_ff || !rsp_stall;

   always_comb begin
      rise_in = rise_ff;
      fall_in = fall_ff;
      inv_in  = inv_ff;
      en_in   = en_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_RISE_RATE:    rise_in = csr_write_data;
            CSR_FALL_RATE:    fall_in = csr_write_data;
            CSR_INVERT_DIR:   inv_in  = csr_write_data[0];
            CSR_MOTOR_ENABLE: en_in   = csr_write_data[0];
            default:          rise_in = rise_ff;
         endcase
      end
   end

   always_comb begin
      type_in     = type_ff;
      now_in      = now_ff;
      value_in    = value_ff;
      cur_in      = cur_ff;
      tgt_in      = tgt_ff;
      rate_in     = rate_ff;
      acc_in      = acc_ff;
      last_in     = last_ff;
      fwd_in      = fwd_ff;
      prod_in     = prod_ff;
      cnt_in      = cnt_ff;
      vld_in      = vld_ff && rsp_stall;
      pulse_in    = pulse_ff;
      dir_in      = dir_ff;
      pos_in      = pos_ff;
      mov_in      = mov_ff;
      last_run_in = last_run_ff;

      if (ctl.start) begin
         type_in  = req_type;
         now_in   = req_now_us;
         value_in = req_position_value[PB-1:0];
         cnt_in   = '0;
      end

      if (ctl.exec) begin
         unique case (ctl.op)
            OP_NOP: begin
               cnt_in = cnt_ff;
            end
            OP_MOVE: begin
               tgt_in  = value_ff;
               rate_in = (value_ff >= cur_ff) ? rise_eff : fall_eff;
            end
            OP_SETPOS: begin
               cur_in  = value_ff;
               tgt_in  = value_ff;
               acc_in  = '0;
               last_in = now_ff;
            end
            OP_SYNC: begin
               acc_in  = '0;
               last_in = now_ff;
            end
            OP_MUL: begin
               prod_in = PROD_W'(rate_ff) * PROD_W'(dt);
               last_in = now_ff;
            end
            OP_ACCUM: begin
               acc_in = (|sum[SUM_W-1:ACC_W]) ? '1 : sum[ACC_W-1:0];
            end
            OP_STEP: begin
               cur_in      = cur_step;
               fwd_in      = step_up;
               acc_in      = acc_ff - ONE_STEP_UNITS;
               cnt_in      = cnt_ff + CNT_W'(1);
               vld_in      = 1'b1;
               pulse_in    = 1'b1;
               dir_in      = step_up ^ inv_ff;
               pos_in      = POS_PORT_W'(cur_step);
               mov_in      = (cur_step != tgt_ff);
               last_run_in = !more;
            end
            OP_STATUS: begin
               vld_in      = 1'b1;
               pulse_in    = 1'b0;
               dir_in      = fwd_ff ^ inv_ff;
               pos_in      = POS_PORT_W'(cur_ff);
               mov_in      = (cur_ff != tgt_ff);
               last_run_in = 1'b1;
            end
            default: begin
               cnt_in = cnt_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rise_ff <= DEFAULT_RATE;
         fall_ff <= DEFAULT_RATE;
         inv_ff  <= 1'b0;
         en_ff   <= 1'b1;
         cur_ff  <= '0;
         tgt_ff  <= '0;
         rate_ff <= DEFAULT_RATE;
         acc_ff  <= '0;
         last_ff <= '0;
         fwd_ff  <= 1'b1;
         cnt_ff  <= '0;
         vld_ff  <= 1'b0;
      end else begin
         rise_ff <= rise_in;
         fall_ff <= fall_in;
         inv_ff  <= inv_in;
         en_ff   <= en_in;
         cur_ff  <= cur_in;
         tgt_ff  <= tgt_in;
         rate_ff <= rate_in;
         acc_ff  <= acc_in;
         last_ff <= last_in;
         fwd_ff  <= fwd_in;
         cnt_ff  <= cnt_in;
         vld_ff  <= vld_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      type_ff     <= type_in;
      now_ff      <= now_in;
      value_ff    <= value_in;
      prod_ff     <= prod_in;
      pulse_ff    <= pulse_in;
      dir_ff      <= dir_in;
      pos_ff      <= pos_in;
      mov_ff      <= mov_in;
      last_run_ff <= last_run_in;
   end

   assign rsp_valid           = vld_ff;
   assign rsp_step_pulse      = pulse_ff;
   assign rsp_direction_level = dir_ff;
   assign rsp_position_now    = pos_ff;
   assign rsp_moving          = mov_ff;
   assign rsp_last_of_run     = last_run_ff;

endmodule

`default_nettype wire

[src/stepper_position_step_generator_core.sv]
// Results: a move-to, set-position, disabled tick, unknown request, tick at target or
// tick without a whole step gives one status result; a stepping tick gives its pulses,
// one pulse per cycle while rsp_stall is low (at most 16), and no status result.
// A new request is taken only once the sequencer is idle again, after its last result
// has entered the result register. Reset (synchronous, active high):
// rates 256, invert 0, enable 1, position, target, accumulator and time 0, forward.
//
// Top level of the constant-rate stepper step generator.
// Depends on spg_pkg, spg_sequencer and spg_datapath.
`default_nettype none

module stepper_position_step_generator_core #(
   parameter int MAX_STEPS_PER_TICK = spg_pkg::MAX_STEPS_DEFAULT,
   parameter int POSITION_BITS      = spg_pkg::POSITION_BITS_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // config write port
   input  wire logic                                  csr_write_enable,
   input  wire logic [spg_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire logic [spg_pkg::RATE_W-1:0]            csr_write_data,
   // request channel
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic [1:0]                            req_type,
   input  wire logic [spg_pkg::TIME_W-1:0]            req_now_us,
   input  wire logic signed [spg_pkg::POS_PORT_W-1:0] req_position_value,
   // result channel
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic                                       rsp_step_pulse,
   output logic                                       rsp_direction_level,
   output logic signed [spg_pkg::POS_PORT_W-1:0]      rsp_position_now,
   output logic                                       rsp_moving,
   output logic                                       rsp_last_of_run
);
   import spg_pkg::*;

   // The sequencer walks a twelve-word microprogram. The first words dispatch
   // on request kind; a stepping tick runs multiply (rate * elapsed us),
   // saturating accumulate, then a single STEP word that loops on itself
   // while another whole step, distance and step budget remain. Every word
   // that emits a result waits for the result register to be free, so the
   // sequencer moves on to the next request while the final result waits.

   dp_ctl_type   ctl;
   dp_flags_type flags;

   spg_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .flags     (flags),
      .ctl       (ctl)
   );

   spg_datapath #(
      .MAX_STEPS_PER_TICK (MAX_STEPS_PER_TICK),
      .POSITION_BITS      (POSITION_BITS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .req_type            (req_type),
      .req_now_us          (req_now_us),
      .req_position_value  (req_position_value),
      .ctl                 (ctl),
      .flags               (flags),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_step_pulse      (rsp_step_pulse),
      .rsp_direction_level (rsp_direction_level),
      .rsp_position_now    (rsp_position_now),
      .rsp_moving          (rsp_moving),
      .rsp_last_of_run     (rsp_last_of_run)
   );

endmodule

`default_nettype wire

[src/spg_checker.sv]
// Port-level checker for the stepper step generator, bound to the top level.
// Depends on spg_pkg and the assertion macro header.
`default_nettype none
`include "stepper_position_step_generator_core_macros.svh"

module spg_checker (
   input wire logic                                  clock,
   input wire logic                                  reset,
   input wire logic                                  req_valid,
   input wire logic                                  req_stall,
   input wire logic                                  rsp_valid,
   input wire logic                                  rsp_stall,
   input wire logic                                  rsp_step_pulse,
   input wire logic                                  rsp_direction_level,
   input wire logic signed [spg_pkg::POS_PORT_W-1:0] rsp_position_now,
   input wire logic                                  rsp_moving,
   input wire logic                                  rsp_last_of_run
);
   import spg_pkg::*;

   logic [POS_PORT_W+3:0] rsp_word;
   logic                  arrive;

   assign rsp_word = {rsp_step_pulse, rsp_direction_level, rsp_position_now,
                      rsp_moving, rsp_last_of_run};
   assign arrive   = rsp_valid && rsp_step_pulse && !rsp_moving;

   // a stalled result holds
   `SPG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_word))

   // one request in flight at a time
   `SPG_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)

   // a status result always closes its run
   `SPG_ASSERT_HOLDS(a_status_is_last, clock, reset, rsp_valid && !rsp_step_pulse, rsp_last_of_run)

   // the pulse that reaches the target closes its run
   `SPG_ASSERT_HOLDS(a_arrive_is_last, clock, reset, arrive, rsp_last_of_run)

endmodule

bind stepper_position_step_generator_core spg_checker u_spg_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_stall           (req_stall),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_step_pulse      (rsp_step_pulse),
   .rsp_direction_level (rsp_direction_level),
   .rsp_position_now    (rsp_position_now),
   .rsp_moving          (rsp_moving),
   .rsp_last_of_run     (rsp_last_of_run)
);

`default_nettype wire
